// ===== design/multi_fan_tachometer_assert.svh =====
// ----------------------------------------------------------------------------
// Multi-fan tachometer assertion macros
// Concurrent check wrappers used by the tachometer RTL. Define ASSERT_OFF
// to compile the checks out.
// ----------------------------------------------------------------------------
`ifndef MULTI_FAN_TACHOMETER_ASSERT_SVH
`define MULTI_FAN_TACHOMETER_ASSERT_SVH

`ifndef ASSERT_OFF
// check on clk_i, masked while rst_ni is low
`define MFT_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("%m: check failed");
// check on clk_i, also evaluated during reset
`define MFT_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("%m: check failed in or around reset");
`else
`define MFT_ASSERT(lbl, prop)
`define MFT_ASSERT_RST(lbl, prop)
`endif

`endif

// ===== design/mft_pkg.sv =====
// ----------------------------------------------------------------------------
// Multi-fan tachometer package
// Shared widths, codes, reset values and lane interface structs.
// ----------------------------------------------------------------------------
package mft_pkg;

  // field widths
  localparam int unsigned TICK_W    = 32;
  localparam int unsigned PINS_W    = 14;
  localparam int unsigned FAN_IDX_W = 4;
  localparam int unsigned TGT_W     = 7;
  localparam int unsigned RPM_W     = 16;
  localparam int unsigned PCT_W     = 7;
  localparam int unsigned STAT_W    = 2;
  localparam int unsigned CMD_W     = 2;

  // configuration register widths
  localparam int unsigned TIMEOUT_W = 20;
  localparam int unsigned RPMK_W    = 24;
  localparam int unsigned RATED_W   = 16;
  localparam int unsigned FASTN_W   = 4;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 24;

  // stream bus widths
  localparam int unsigned S_DATA_W = 32;
  localparam int unsigned S_USER_W = 8;
  localparam int unsigned M_DATA_W = 32;

  // divider operand width (rpm constant and percent dividend both fit)
  localparam int unsigned DIV_W = 24;

  // floor(x/100) for 16-bit x: (x * RECIP_100) >> RECIP_SH, exact over the range
  localparam logic [31:0] RECIP_100 = 32'd83887;
  localparam int unsigned RECIP_SH  = 23;
  localparam int unsigned HUND_W    = 10;
  localparam int unsigned SLOW_W    = 20;

  localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;
  localparam logic [RPM_W-1:0] RPM_MAX  = 16'hFFFF;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RPM_K      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RATED_FAST = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RATED_SLOW = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FAST_N     = 3'd4;

  // register reset values
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST    = 20'd20000;
  localparam logic [RPMK_W-1:0]    RPM_K_RST      = 24'd300000;
  localparam logic [RATED_W-1:0]   RATED_FAST_RST = 16'd9000;
  localparam logic [RATED_W-1:0]   RATED_SLOW_RST = 16'd5000;
  localparam logic [FASTN_W-1:0]   FAST_N_RST     = 4'd2;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK    = 2'd0,
    CMD_REFRESH = 2'd1,
    CMD_CACHED  = 2'd2,
    CMD_RSVD    = 2'd3
  } cmd_e;

  typedef enum logic [STAT_W-1:0] {
    ST_NORMAL = 2'd0,
    ST_STALL  = 2'd1,
    ST_SLOW   = 2'd2,
    ST_SPIN   = 2'd3
  } status_e;

  // control from the query engine into one lane
  typedef struct packed {
    logic              tick;
    logic [TICK_W-1:0] tick_new;
    logic              rpm_we;
    logic [RPM_W-1:0]  rpm;
  } lane_ctrl_t;

  // state of one lane as seen by the merge mux
  typedef struct packed {
    logic [TICK_W-1:0] last_edge;
    logic [TICK_W-1:0] period;
    logic [RPM_W-1:0]  cached_rpm;
  } lane_state_t;

endpackage

// ===== design/mft_lane.sv =====
// ----------------------------------------------------------------------------
// Tachometer lane
// Per-fan edge detector and period capture, plus the cached RPM.
// ----------------------------------------------------------------------------
module mft_lane
  import mft_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  lane_ctrl_t  ctrl_i,
  input  logic        pin_i,
  output lane_state_t state_o
);

  logic              prev_q;
  logic [TICK_W-1:0] last_edge_q;
  logic [TICK_W-1:0] period_q;
  logic [RPM_W-1:0]  rpm_q;

  // falling edge on the FG pin at a tick
  logic fall;
  assign fall = ctrl_i.tick & prev_q & ~pin_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q      <= 1'b0;
      last_edge_q <= '0;
      period_q    <= '0;
      rpm_q       <= '0;
    end else begin
      if (ctrl_i.tick) begin
        prev_q <= pin_i;
      end
      if (fall) begin
        period_q    <= ctrl_i.tick_new - last_edge_q;
        last_edge_q <= ctrl_i.tick_new;
      end
      if (ctrl_i.rpm_we) begin
        rpm_q <= ctrl_i.rpm;
      end
    end
  end

  assign state_o.last_edge  = last_edge_q;
  assign state_o.period     = period_q;
  assign state_o.cached_rpm = rpm_q;

endmodule

// ===== design/mft_div.sv =====
// ----------------------------------------------------------------------------
// Tachometer divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mft_div
  import mft_pkg::*;
#(
  parameter int unsigned W = 24
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [W-1:0] dividend_i,
  input  logic [W-1:0] divisor_i,
  output logic         busy_o,
  output logic         done_o,
  output logic [W-1:0] quotient_o
);

  localparam int unsigned CntW = (W > 1) ? $clog2(W) : 1;

  logic [W-1:0]    rem_q;
  logic [W-1:0]    quo_q;
  logic [W-1:0]    dvs_q;
  logic [CntW-1:0] cnt_q;
  logic            busy_q;
  logic            done_q;

  // one trial subtraction step
  logic [W:0]   shifted;
  logic [W:0]   diff;
  logic         ge;
  assign shifted = {rem_q, quo_q[W-1]};
  assign diff    = shifted - {1'b0, dvs_q};
  assign ge      = ~diff[W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q  <= '0;
      quo_q  <= '0;
      dvs_q  <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        rem_q  <= '0;
        quo_q  <= dividend_i;
        dvs_q  <= divisor_i;
        cnt_q  <= '0;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        rem_q <= ge ? diff[W-1:0] : shifted[W-1:0];
        quo_q <= {quo_q[W-2:0], ge};
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign busy_o     = busy_q;
  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// ===== design/multi_fan_tachometer.sv =====
// ----------------------------------------------------------------------------
// Multi-fan tachometer
// Measures FG pulse periods of FAN_NUM fans in parallel lanes and answers
// per-fan speed, percent of rated speed and status queries.
//
//   channel  | dir | handshake                  | payload
//   ---------+-----+----------------------------+-------------------------------
//   s_axis   | in  | s_axis_tvalid_i / tready_o | tdata: pins, fan, target
//            |     |                            | tuser: cmd
//   m_axis   | out | m_axis_tvalid_o / tready_i | tdata: num, rpm, pct, status
//   cfg      | in  | cfg_we_i                   | cfg_index_i, cfg_data_i
//
// All lanes sample their pin in the cycle that a tick beat is accepted.
// A query steps through S_FETCH, S_PCT, S_DIV_PCT when the percent divides
// rather than saturates, and S_STATUS; a refresh that divides adds S_DIV_RPM:
// each quotient goes through the shared 24-step divider, one bit a cycle.
// One query is in flight at a time; ticks and new beats are taken while a
// result waits in the output register, and a finished query holds until
// that register is free. Reset is asynchronous and clears all lane state.
// ----------------------------------------------------------------------------
`include "multi_fan_tachometer_assert.svh"

module multi_fan_tachometer
  import mft_pkg::*;
#(
  parameter int unsigned FAN_NUM = 14
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // stream in
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  // fan_pins[13:0], query_fan[17:14], target_percent[24:18], zero fill
  input  logic [S_DATA_W-1:0]  s_axis_tdata_i,
  // cmd[1:0], zero fill
  input  logic [S_USER_W-1:0]  s_axis_tuser_i,
  // stream out
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  // fan_number[3:0], speed_rpm[19:4], speed_pct[26:20],
  // fan_status[28:27], zero fill
  output logic [M_DATA_W-1:0]  m_axis_tdata_o,
  // configuration writes
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_DAT_W-1:0] cfg_data_i
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_FETCH,
    S_DIV_RPM,
    S_PCT,
    S_DIV_PCT,
    S_STATUS
  } state_e;

  // input beat fields
  logic [PINS_W-1:0]    in_pins;
  logic [FAN_IDX_W-1:0] in_fan;
  logic [TGT_W-1:0]     in_tgt;
  cmd_e                 in_cmd;
  assign in_pins = s_axis_tdata_i[PINS_W-1:0];
  assign in_fan  = s_axis_tdata_i[PINS_W +: FAN_IDX_W];
  assign in_tgt  = s_axis_tdata_i[PINS_W+FAN_IDX_W +: TGT_W];
  assign in_cmd  = cmd_e'(s_axis_tuser_i[CMD_W-1:0]);

  // configuration registers
  logic [TIMEOUT_W-1:0] timeout_q;
  logic [RPMK_W-1:0]    rpm_k_q;
  logic [RATED_W-1:0]   rated_fast_q;
  logic [RATED_W-1:0]   rated_slow_q;
  logic [FASTN_W-1:0]   fast_n_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q    <= TIMEOUT_RST;
      rpm_k_q      <= RPM_K_RST;
      rated_fast_q <= RATED_FAST_RST;
      rated_slow_q <= RATED_SLOW_RST;
      fast_n_q     <= FAST_N_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_TIMEOUT:    timeout_q    <= cfg_data_i[TIMEOUT_W-1:0];
        CFG_RPM_K:      rpm_k_q      <= cfg_data_i[RPMK_W-1:0];
        CFG_RATED_FAST: rated_fast_q <= cfg_data_i[RATED_W-1:0];
        CFG_RATED_SLOW: rated_slow_q <= cfg_data_i[RATED_W-1:0];
        CFG_FAST_N:     fast_n_q     <= cfg_data_i[FASTN_W-1:0];
        default: ;
      endcase
    end
  end

  // FSM and datapath registers
  state_e               state_q;
  logic [TICK_W-1:0]    tick_q;
  logic [FAN_IDX_W-1:0] fan_q;
  logic [TGT_W-1:0]     tgt_q;
  logic                 refresh_q;
  logic [RPM_W-1:0]     rpm_q;
  logic [RATED_W-1:0]   rated_q;
  logic [HUND_W-1:0]    hund_q;
  logic [SLOW_W-1:0]    tgt7_q;
  logic [PCT_W-1:0]     pct_q;
  logic                 rpm_we_q;
  logic                 div_start_q;
  logic [DIV_W-1:0]     div_dvd_q;
  logic [DIV_W-1:0]     div_dvs_q;
  logic                 m_valid_q;
  logic [FAN_IDX_W-1:0] num_out_q;
  logic [RPM_W-1:0]     rpm_out_q;
  logic [PCT_W-1:0]     pct_out_q;
  status_e              stat_out_q;

  logic                 s_fire;
  logic                 tick_fire;
  logic [TICK_W-1:0]    tick_new;
  assign s_axis_tready_o = (state_q == S_IDLE);
  assign s_fire          = s_axis_tvalid_i & s_axis_tready_o;
  assign tick_fire       = s_fire & (in_cmd == CMD_TICK);
  assign tick_new        = tick_q + 1'b1;

  // lanes
  lane_ctrl_t  lane_ctrl  [FAN_NUM];
  lane_state_t lane_state [FAN_NUM];
  logic        lane_pin   [FAN_NUM];

  always_comb begin
    for (int n = 0; n < FAN_NUM; n++) begin
      lane_ctrl[n].tick     = tick_fire;
      lane_ctrl[n].tick_new = tick_new;
      lane_ctrl[n].rpm_we   = rpm_we_q & (int'(fan_q) == n);
      lane_ctrl[n].rpm      = rpm_q;
    end
  end

  for (genvar n = 0; n < FAN_NUM; n++) begin : g_lane
    // fans past the pin field see a constant low level
    if (n < PINS_W) begin : g_pin
      assign lane_pin[n] = in_pins[n];
    end else begin : g_nopin
      assign lane_pin[n] = 1'b0;
    end
    mft_lane u_lane (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (lane_ctrl[n]),
      .pin_i   (lane_pin[n]),
      .state_o (lane_state[n])
    );
  end

  // merge: pick the queried lane
  lane_state_t sel;
  always_comb begin
    sel = '0;
    for (int n = 0; n < FAN_NUM; n++) begin
      if (int'(fan_q) == n) begin
        sel = lane_state[n];
      end
    end
  end

  // shared divider
  logic             div_busy;
  logic             div_done;
  logic [DIV_W-1:0] div_quo;

  mft_div #(
    .W (DIV_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start_q),
    .dividend_i (div_dvd_q),
    .divisor_i  (div_dvs_q),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // fetch-stage arithmetic
  logic [TICK_W-1:0]  elapsed;
  logic               timed_out;
  logic [RATED_W-1:0] rated_sel;
  logic [39:0]        hund_prod;
  assign elapsed   = tick_q - sel.last_edge;
  assign timed_out = elapsed > {{(TICK_W-TIMEOUT_W){1'b0}}, timeout_q};
  assign rated_sel = (fan_q < fast_n_q) ? rated_fast_q : rated_slow_q;
  assign hund_prod = {24'b0, rated_sel} * 40'(RECIP_100);

  // percent and status arithmetic
  logic [DIV_W-1:0]  pct_dvd;
  logic [SLOW_W-1:0] tgt7;
  logic [SLOW_W-1:0] rpm10;
  logic              is_slow;
  status_e           stat_d;
  assign pct_dvd = {{(DIV_W-RPM_W){1'b0}}, rpm_q} * DIV_W'(100);
  assign tgt7    = SLOW_W'(hund_q) * SLOW_W'(tgt_q) * SLOW_W'(7);
  // rpm < floor(t/10) exactly when 10*(rpm+1) <= t
  assign rpm10   = (SLOW_W'(rpm_q) + 1'b1) * SLOW_W'(10);
  assign is_slow = rpm10 <= tgt7_q;

  always_comb begin
    priority if (tgt_q == '0) begin
      stat_d = (rpm_q != '0) ? ST_SPIN : ST_NORMAL;
    end else if (rpm_q == '0) begin
      stat_d = ST_STALL;
    end else if (is_slow) begin
      stat_d = ST_SLOW;
    end else begin
      stat_d = ST_NORMAL;
    end
  end

  // query sequencer with output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      tick_q      <= '0;
      fan_q       <= '0;
      tgt_q       <= '0;
      refresh_q   <= 1'b0;
      rpm_q       <= '0;
      rated_q     <= '0;
      hund_q      <= '0;
      tgt7_q      <= '0;
      pct_q       <= '0;
      rpm_we_q    <= 1'b0;
      div_start_q <= 1'b0;
      div_dvd_q   <= '0;
      div_dvs_q   <= '0;
      m_valid_q   <= 1'b0;
      num_out_q   <= '0;
      rpm_out_q   <= '0;
      pct_out_q   <= '0;
      stat_out_q  <= ST_NORMAL;
    end else begin
      rpm_we_q    <= 1'b0;
      div_start_q <= 1'b0;
      if (m_valid_q && m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (tick_fire) begin
            tick_q <= tick_new;
          end else if (s_fire && (in_cmd != CMD_RSVD) && (int'(in_fan) < FAN_NUM)) begin
            fan_q     <= in_fan;
            tgt_q     <= in_tgt;
            refresh_q <= (in_cmd == CMD_REFRESH);
            state_q   <= S_FETCH;
          end
        end

        S_FETCH: begin
          rated_q <= rated_sel;
          hund_q  <= hund_prod[RECIP_SH +: HUND_W];
          state_q <= S_PCT;
          priority if (!refresh_q) begin
            rpm_q <= sel.cached_rpm;
          end else if (timed_out) begin
            rpm_q    <= '0;
            rpm_we_q <= 1'b1;
          end else if (sel.period == '0) begin
            rpm_q <= sel.cached_rpm;
          end else if (sel.period[TICK_W-1:DIV_W] != '0) begin
            // period beyond any dividend: quotient is zero
            rpm_q    <= '0;
            rpm_we_q <= 1'b1;
          end else begin
            div_dvd_q   <= rpm_k_q;
            div_dvs_q   <= sel.period[DIV_W-1:0];
            div_start_q <= 1'b1;
            state_q     <= S_DIV_RPM;
          end
        end

        S_DIV_RPM: begin
          if (div_done) begin
            rpm_q    <= (div_quo[DIV_W-1:RPM_W] != '0) ? RPM_MAX : div_quo[RPM_W-1:0];
            rpm_we_q <= 1'b1;
            state_q  <= S_PCT;
          end
        end

        S_PCT: begin
          tgt7_q <= tgt7;
          priority if ({{(RATED_W-RPM_W){1'b0}}, rpm_q} > rated_q) begin
            pct_q   <= PCT_FULL;
            state_q <= S_STATUS;
          end else if (rated_q == '0) begin
            pct_q   <= '0;
            state_q <= S_STATUS;
          end else begin
            div_dvd_q   <= pct_dvd;
            div_dvs_q   <= {{(DIV_W-RATED_W){1'b0}}, rated_q};
            div_start_q <= 1'b1;
            state_q     <= S_DIV_PCT;
          end
        end

        S_DIV_PCT: begin
          if (div_done) begin
            pct_q   <= div_quo[PCT_W-1:0];
            state_q <= S_STATUS;
          end
        end

        S_STATUS: begin
          if (!m_valid_q || m_axis_tready_i) begin
            m_valid_q  <= 1'b1;
            num_out_q  <= fan_q + 1'b1;
            rpm_out_q  <= rpm_q;
            pct_out_q  <= pct_q;
            stat_out_q <= stat_d;
            state_q    <= S_IDLE;
          end
        end

        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {{(M_DATA_W-FAN_IDX_W-RPM_W-PCT_W-STAT_W){1'b0}},
                            stat_out_q, pct_out_q, rpm_out_q, num_out_q};

  // checks
  `MFT_ASSERT_RST(a_no_valid_in_reset, !rst_ni |-> !m_valid_q)
  `MFT_ASSERT(a_ready_div_idle, s_axis_tready_o |-> !div_busy)
  `MFT_ASSERT(a_done_in_wait, div_done |-> (state_q == S_DIV_RPM || state_q == S_DIV_PCT))
  `MFT_ASSERT(a_pct_range, m_valid_q |-> (pct_out_q <= PCT_FULL))

endmodule

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// Multi-fan tachometer testbench
// Drives tick and query beats into the tachometer stream port, with random
// gaps on both sides, and checks every reading against a hand-typed value or
// an in-bench model of the tick counter, per-fan edge timing and RPM, percent
// and status math. A short directed table comes first. Random phases under
// several register settings follow, with generated FG waveforms and pin noise.
// ----------------------------------------------------------------------------
module tb_top
  import mft_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_HALF    = 5;
  localparam int RST_CYC     = 11;
  localparam int FAN_CNT     = 14;
  localparam int MAX_GAP     = 14;
  localparam int SETTLE_CYC  = 150;
  localparam int HOLD_CYC    = 2500;
  localparam int NUM_DIR     = 23;
  localparam int NUM_PHASE   = 7;
  localparam int PHASE_ITEMS = 170;

  // one reading as it leaves the block
  typedef struct packed {
    logic [FAN_IDX_W-1:0] fan_number;
    logic [RPM_W-1:0]     speed_rpm;
    logic [PCT_W-1:0]     speed_pct;
    status_e              fan_status;
  } tach_result_t;

  // one input beat, with an optional hand-typed reading
  typedef struct {
    cmd_e                 cmd;
    logic [PINS_W-1:0]    pins;
    logic [FAN_IDX_W-1:0] fan;
    logic [TGT_W-1:0]     tgt;
    bit                   typed;
    tach_result_t         res;
  } stim_row_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 s_axis_tvalid_i;
  logic                 s_axis_tready_o;
  logic [S_DATA_W-1:0]  s_axis_tdata_i;
  logic [S_USER_W-1:0]  s_axis_tuser_i;
  logic                 m_axis_tvalid_o;
  logic                 m_axis_tready_i;
  logic [M_DATA_W-1:0]  m_axis_tdata_o;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [CFG_DAT_W-1:0] cfg_data_i;

  // model registers
  logic [TIMEOUT_W-1:0] timeout_cfg    = TIMEOUT_RST;
  logic [RPMK_W-1:0]    rpm_k_cfg      = RPM_K_RST;
  logic [RATED_W-1:0]   rated_fast_cfg = RATED_FAST_RST;
  logic [RATED_W-1:0]   rated_slow_cfg = RATED_SLOW_RST;
  logic [FASTN_W-1:0]   fast_n_cfg     = FAST_N_RST;

  // model state
  logic [TICK_W-1:0] tick_q = '0;
  logic [PINS_W-1:0] pin_q  = '0;
  logic [TICK_W-1:0] edge_q   [FAN_CNT] = '{default: '0};
  logic [TICK_W-1:0] period_q [FAN_CNT] = '{default: '0};
  logic [RPM_W-1:0]  rpm_q    [FAN_CNT] = '{default: '0};

  tach_result_t rpm_expect_q[$];
  int           mismatch_cnt = 0;

  // idling control
  bit tx_idle = 1'b1;
  bit rx_idle = 1'b1;
  int rx_hold = 0;

  // FG waveform generator, one half period per fan (0 = stopped)
  int                half_per [FAN_CNT];
  int                ph_left  [FAN_CNT];
  logic [PINS_W-1:0] gen_pins = '0;

  // directed beats, from reset values
  stim_row_t dir_tab [NUM_DIR] = '{
    '{CMD_CACHED,  14'h0000, 4'd0,  7'd0,   1'b1, '{4'd1,  16'd0,     7'd0,   ST_NORMAL}},
    '{CMD_REFRESH, 14'h0000, 4'd13, 7'd100, 1'b1, '{4'd14, 16'd0,     7'd0,   ST_STALL}},
    '{CMD_CACHED,  14'h0000, 4'd14, 7'd127, 1'b0, '0},
    '{CMD_REFRESH, 14'h0000, 4'd15, 7'd0,   1'b0, '0},
    '{CMD_RSVD,    14'h3FFF, 4'd15, 7'd127, 1'b0, '0},
    '{CMD_TICK,    14'h3FFF, 4'd0,  7'd0,   1'b0, '0},
    '{CMD_TICK,    14'h0000, 4'd0,  7'd0,   1'b0, '0},
    '{CMD_TICK,    14'h3FFF, 4'd0,  7'd0,   1'b0, '0},
    '{CMD_TICK,    14'h0000, 4'd0,  7'd0,   1'b0, '0},
    // period 2 everywhere: the quotient saturates
    '{CMD_REFRESH, 14'h0000, 4'd0,  7'd100, 1'b1, '{4'd1,  16'hFFFF, 7'd100, ST_NORMAL}},
    '{CMD_REFRESH, 14'h0000, 4'd13, 7'd0,   1'b1, '{4'd14, 16'hFFFF, 7'd100, ST_SPIN}},
    '{CMD_REFRESH, 14'h0000, 4'd5,  7'd127, 1'b0, '0},
    '{CMD_TICK,    14'h2AAA, 4'd0,  7'd0,   1'b0, '0},
    '{CMD_TICK,    14'h1555, 4'd0,  7'd0,   1'b0, '0},
    '{CMD_TICK,    14'h0000, 4'd0,  7'd0,   1'b0, '0},
    '{CMD_TICK,    14'h3FFF, 4'd0,  7'd0,   1'b0, '0},
    '{CMD_TICK,    14'h3FFF, 4'd0,  7'd0,   1'b0, '0},
    '{CMD_TICK,    14'h0000, 4'd0,  7'd0,   1'b0, '0},
    '{CMD_REFRESH, 14'h0000, 4'd1,  7'd1,   1'b0, '0},
    '{CMD_REFRESH, 14'h0000, 4'd2,  7'd50,  1'b0, '0},
    '{CMD_CACHED,  14'h0000, 4'd7,  7'd100, 1'b0, '0},
    '{CMD_CACHED,  14'h0000, 4'd13, 7'd0,   1'b0, '0},
    '{CMD_REFRESH, 14'h0000, 4'd8,  7'd100, 1'b0, '0}
  };

  // clock
  always #(CLK_HALF) clk_i = ~clk_i;

  multi_fan_tachometer #(
    .FAN_NUM(FAN_CNT)
  ) i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  // tachometer model: advances state, returns 1 when a reading is due
  function automatic bit tach_predict(input stim_row_t row, output tach_result_t res);
    logic [TICK_W-1:0] elapsed;
    logic [TICK_W-1:0] quo;
    logic [TICK_W-1:0] rpm;
    logic [TICK_W-1:0] rated;
    logic [TICK_W-1:0] pct;
    logic [TICK_W-1:0] tgt_rpm;
    status_e           st;
    res = '0;
    if (row.cmd == CMD_TICK) begin
      tick_q = tick_q + 1'b1;
      for (int n = 0; n < FAN_CNT; n++) begin
        // falling FG edge closes a period
        if (pin_q[n] && !row.pins[n]) begin
          period_q[n] = tick_q - edge_q[n];
          edge_q[n]   = tick_q;
        end
      end
      pin_q = row.pins;
      return 1'b0;
    end
    if (row.cmd == CMD_RSVD || row.fan >= FAN_CNT) return 1'b0;
    if (row.cmd == CMD_REFRESH) begin
      elapsed = tick_q - edge_q[row.fan];
      if (elapsed > timeout_cfg) begin
        rpm_q[row.fan] = '0;
      end else if (period_q[row.fan] != 0) begin
        quo = rpm_k_cfg / period_q[row.fan];
        rpm_q[row.fan] = (quo > RPM_MAX) ? RPM_MAX : quo[RPM_W-1:0];
      end
    end
    rpm   = rpm_q[row.fan];
    rated = (row.fan < fast_n_cfg) ? rated_fast_cfg : rated_slow_cfg;
    if (rpm > rated) pct = PCT_FULL;
    else if (rated == 0) pct = '0;
    else pct = (rpm * 100) / rated;
    // status against the commanded target
    tgt_rpm = (rated / 100) * row.tgt;
    if (row.tgt != 0) begin
      if (rpm == 0) st = ST_STALL;
      else if (rpm < (tgt_rpm * 7) / 10) st = ST_SLOW;
      else st = ST_NORMAL;
    end else begin
      st = (rpm != 0) ? ST_SPIN : ST_NORMAL;
    end
    res.fan_number = row.fan + 1'b1;
    res.speed_rpm  = rpm[RPM_W-1:0];
    res.speed_pct  = pct[PCT_W-1:0];
    res.fan_status = st;
    return 1'b1;
  endfunction

  // compare one output beat with the oldest expected reading
  task automatic check_reading(input logic [M_DATA_W-1:0] d);
    tach_result_t got;
    tach_result_t want;
    got.fan_number = d[3:0];
    got.speed_rpm  = d[19:4];
    got.speed_pct  = d[26:20];
    got.fan_status = status_e'(d[28:27]);
    if (rpm_expect_q.size() == 0) begin
      $display("%0t: reading with none expected, actual %h", $time, d);
      mismatch_cnt++;
      return;
    end
    want = rpm_expect_q.pop_front();
    if (got.fan_number !== want.fan_number) begin
      $display("%0t: fan_number expected %0d actual %0d", $time, want.fan_number,
               got.fan_number);
      mismatch_cnt++;
    end
    if (got.speed_rpm !== want.speed_rpm) begin
      $display("%0t: speed_rpm expected %0d actual %0d", $time, want.speed_rpm,
               got.speed_rpm);
      mismatch_cnt++;
    end
    if (got.speed_pct !== want.speed_pct) begin
      $display("%0t: speed_pct expected %0d actual %0d", $time, want.speed_pct,
               got.speed_pct);
      mismatch_cnt++;
    end
    if (got.fan_status !== want.fan_status) begin
      $display("%0t: fan_status expected %0d actual %0d", $time, want.fan_status,
               got.fan_status);
      mismatch_cnt++;
    end
  endtask

  // send one beat after a random gap when tx_idle is set, predict on acceptance
  task automatic send_beat(input stim_row_t row);
    int           gap;
    bit           has_res;
    tach_result_t res;
    gap = tx_idle ? $urandom_range(0, MAX_GAP) : 0;
    repeat (gap) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {7'd0, row.tgt, row.fan, row.pins};
    s_axis_tuser_i  <= {6'd0, row.cmd};
    do @(posedge clk_i); while (!s_axis_tready_o);
    has_res = tach_predict(row, res);
    if (row.typed) rpm_expect_q.push_back(row.res);
    else if (has_res) rpm_expect_q.push_back(res);
  endtask

  // stop sending, wait for all readings, then let the block settle
  task automatic drain_results();
    s_axis_tvalid_i <= 1'b0;
    while (rpm_expect_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    case (idx)
      CFG_TIMEOUT:    timeout_cfg    = val[TIMEOUT_W-1:0];
      CFG_RPM_K:      rpm_k_cfg      = val[RPMK_W-1:0];
      CFG_RATED_FAST: rated_fast_cfg = val[RATED_W-1:0];
      CFG_RATED_SLOW: rated_slow_cfg = val[RATED_W-1:0];
      CFG_FAST_N:     fast_n_cfg     = val[FASTN_W-1:0];
      default: ;
    endcase
  endtask

  task automatic write_config(input logic [TIMEOUT_W-1:0] t, input logic [RPMK_W-1:0] k,
                              input logic [RATED_W-1:0] rf, input logic [RATED_W-1:0] rs,
                              input logic [FASTN_W-1:0] nf);
    write_reg(CFG_TIMEOUT,    CFG_DAT_W'(t));
    write_reg(CFG_RPM_K,      CFG_DAT_W'(k));
    write_reg(CFG_RATED_FAST, CFG_DAT_W'(rf));
    write_reg(CFG_RATED_SLOW, CFG_DAT_W'(rs));
    write_reg(CFG_FAST_N,     CFG_DAT_W'(nf));
    cfg_we_i <= 1'b0;
  endtask

  // receiver settings change off the active edge
  task automatic set_rx(input int hold, input bit idle);
    s_axis_tvalid_i <= 1'b0;
    @(negedge clk_i);
    rx_hold = hold;
    rx_idle = idle;
    @(posedge clk_i);
  endtask

  // random beats: mostly ticks from the FG generator, plus queries and reserved beats
  task automatic run_random(input int count);
    stim_row_t row;
    int        r;
    int        t;
    for (int i = 0; i < count; i++) begin
      r         = $urandom_range(0, 99);
      row.typed = 1'b0;
      row.res   = '0;
      row.pins  = PINS_W'($urandom);
      row.fan   = FAN_IDX_W'($urandom);
      row.tgt   = TGT_W'($urandom);
      if (r < 62) begin
        row.cmd = CMD_TICK;
        for (int n = 0; n < FAN_CNT; n++) begin
          if (half_per[n] != 0) begin
            ph_left[n]--;
            if (ph_left[n] == 0) begin
              gen_pins[n] = ~gen_pins[n];
              ph_left[n]  = half_per[n];
            end
          end
        end
        // occasional noise on the pins
        if ($urandom_range(0, 9) != 0) row.pins = gen_pins;
      end else if (r < 96) begin
        row.cmd = $urandom_range(0, 1) ? CMD_REFRESH : CMD_CACHED;
        row.fan = FAN_IDX_W'($urandom_range(0, 15));
        t = $urandom_range(0, 9);
        if (t == 0) row.tgt = '0;
        else if (t == 1) row.tgt = 7'd100;
        else if (t == 2) row.tgt = TGT_W'($urandom_range(101, 127));
        else row.tgt = TGT_W'($urandom_range(1, 99));
      end else begin
        row.cmd = CMD_RSVD;
      end
      send_beat(row);
    end
  endtask

  // output side: check accepted beats, then draw the next stall
  initial begin : rx_side
    int   stall;
    logic rdy;
    stall = 0;
    m_axis_tready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        check_reading(m_axis_tdata_o);
        stall = rx_idle ? $urandom_range(0, MAX_GAP) : 0;
      end
      if (rx_hold > 0) begin
        rx_hold--;
        rdy = 1'b0;
      end else if (stall > 0) begin
        stall--;
        rdy = 1'b0;
      end else begin
        rdy = 1'b1;
      end
      m_axis_tready_i <= rdy;
    end
  end

  // main sequence
  initial begin : stim_main
    rst_ni          <= 1'b0;
    s_axis_tvalid_i <= 1'b0;
    s_axis_tdata_i  <= '0;
    s_axis_tuser_i  <= '0;
    cfg_we_i        <= 1'b0;
    cfg_index_i     <= '0;
    cfg_data_i      <= '0;
    repeat (RST_CYC) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) send_beat(dir_tab[i]);

    for (int p = 0; p < NUM_PHASE; p++) begin
      drain_results();
      case (p)
        1: write_config(20'd1,       24'hFFFFFF, 16'd65500, 16'd100,   4'd14);
        2: write_config(20'hFFFFF,   24'd0,      16'd100,   16'd65500, 4'd0);
        3: write_config(20'd1000000, 24'd1,      16'd65535, 16'd0,     4'd15);
        4: write_config(20'd40,      24'd300000, 16'd150,   16'd9050,  4'd7);
        5: write_config(20'd20000,   24'd120000, 16'd0,     16'd65535, 4'd1);
        6: write_config(TIMEOUT_W'($urandom_range(1, 3000)), RPMK_W'($urandom),
                        RATED_W'($urandom), RATED_W'($urandom), FASTN_W'($urandom));
        default: ;
      endcase
      // new FG pattern, a few fans stopped
      for (int n = 0; n < FAN_CNT; n++) begin
        half_per[n] = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 30);
        ph_left[n]  = half_per[n];
      end
      // the long receiver hold backs the block up into its input
      set_rx((p == 5) ? HOLD_CYC : 0, $urandom_range(0, 3) != 0);
      tx_idle = $urandom_range(0, 3) != 0;
      if (p == 0) begin
        run_random(PHASE_ITEMS / 2);
        drain_results();
        run_random(PHASE_ITEMS / 2);
      end else begin
        run_random(PHASE_ITEMS);
      end
    end

    drain_results();
    if (mismatch_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // watchdog
  initial begin : watchdog
    #10ms;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+design
design/mft_pkg.sv
design/mft_lane.sv
design/mft_div.sv
design/multi_fan_tachometer.sv
tb/sv/tb_top.sv
